// ===== hw/rtl/dqts_pkg.sv =====
// shared types and constants of the delta queue timeout scheduler
package dqts_pkg;

  // most expiry results reported on one tick
  localparam int unsigned MaxResults = 16;
  localparam int unsigned NCntW      = $clog2(MaxResults + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CANCEL = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_INSERT_ACK = 2'd0,
    KIND_EXPIRY     = 2'd1,
    KIND_CANCEL_ACK = 2'd2
  } kind_e;

  // which result the output register loads
  typedef enum logic [2:0] {
    EMIT_NONE   = 3'd0,
    EMIT_FULL   = 3'd1,
    EMIT_INSERT = 3'd2,
    EMIT_CANCEL = 3'd3,
    EMIT_PEND   = 3'd4
  } emit_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] delay_ticks;
    logic [7:0]  handler_tag;
    logic [15:0] handler_argument;
    logic [15:0] cancel_id;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [15:0] timer_id;
    logic [7:0]  expired_handler;
    logic [15:0] expired_argument;
    logic        cancel_found;
    logic        last_result;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic  load_req;
    logic  pick_id;
    logic  scan_step;
    logic  place;
    logic  cancel_mark;
    logic  dec_head;
    logic  drop_head;
    logic  take_pend;
    logic  clr_count;
    emit_e emit;
    logic  emit_last;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic out_free;
    logic id_in_use;
    logic scan_more;
    logic scan_hit;
    logic head_zero;
    logic head_cancel;
    logic count_max;
    logic pend_valid;
  } stat_t;

endpackage

// ===== hw/rtl/dqts_ctrl.sv =====
// controller state machine of the delta queue timeout scheduler
module dqts_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_command_i,
  output logic            in_stall_o,
  input  dqts_pkg::stat_t stat_i,
  output dqts_pkg::ctrl_t ctrl_o
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_PICK   = 7'b0000010,
    ST_SCAN   = 7'b0000100,
    ST_PLACE  = 7'b0001000,
    ST_CANCEL = 7'b0010000,
    ST_TICK   = 7'b0100000,
    ST_EXPIRE = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   accept;
  logic   stop;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  // end of an expiry run
  assign stop = stat_i.empty || !stat_i.head_zero ||
                (!stat_i.head_cancel && stat_i.count_max);

  // next state and commands
  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.emit = dqts_pkg::EMIT_NONE;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ctrl_o.load_req = 1'b1;
          case (in_command_i)
            dqts_pkg::CMD_INSERT: state_d = ST_PICK;
            dqts_pkg::CMD_TICK:   state_d = ST_TICK;
            dqts_pkg::CMD_CANCEL: state_d = ST_CANCEL;
            default:              state_d = ST_IDLE;
          endcase
        end
      end
      ST_PICK: begin
        if (stat_i.full) begin
          if (stat_i.out_free) begin
            ctrl_o.emit      = dqts_pkg::EMIT_FULL;
            ctrl_o.emit_last = 1'b1;
            state_d          = ST_IDLE;
          end
        end else begin
          ctrl_o.pick_id = 1'b1;
          if (!stat_i.id_in_use) begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat_i.scan_more && !stat_i.scan_hit) begin
          ctrl_o.scan_step = 1'b1;
        end else begin
          state_d = ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (stat_i.out_free) begin
          ctrl_o.place     = 1'b1;
          ctrl_o.emit      = dqts_pkg::EMIT_INSERT;
          ctrl_o.emit_last = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      ST_CANCEL: begin
        if (stat_i.out_free) begin
          ctrl_o.cancel_mark = 1'b1;
          ctrl_o.emit        = dqts_pkg::EMIT_CANCEL;
          ctrl_o.emit_last   = 1'b1;
          state_d            = ST_IDLE;
        end
      end
      ST_TICK: begin
        if (stat_i.empty) begin
          state_d = ST_IDLE;
        end else begin
          ctrl_o.dec_head  = 1'b1;
          ctrl_o.clr_count = 1'b1;
          state_d          = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (stop) begin
          if (!stat_i.pend_valid) begin
            state_d = ST_IDLE;
          end else if (stat_i.out_free) begin
            ctrl_o.emit      = dqts_pkg::EMIT_PEND;
            ctrl_o.emit_last = 1'b1;
            state_d          = ST_IDLE;
          end
        end else if (stat_i.head_cancel) begin
          ctrl_o.drop_head = 1'b1;
        end else if (stat_i.pend_valid) begin
          // flush the held expiry, it is not the last one
          if (stat_i.out_free) begin
            ctrl_o.emit = dqts_pkg::EMIT_PEND;
          end
        end else begin
          ctrl_o.take_pend = 1'b1;
          ctrl_o.drop_head = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hw/rtl/dqts_datapath.sv =====
// entry storage, scan registers and result register of the scheduler
module dqts_datapath #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dqts_pkg::req_t  in_req_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output dqts_pkg::rsp_t  out_rsp_o,
  input  dqts_pkg::ctrl_t ctrl_i,
  output dqts_pkg::stat_t stat_o
);

  localparam int unsigned LW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = $clog2(QUEUE_DEPTH);

  // entry storage in queue order, head at slot 0
  logic [31:0] delta_q [QUEUE_DEPTH];
  logic [31:0] delta_d [QUEUE_DEPTH];
  logic [15:0] id_q    [QUEUE_DEPTH];
  logic [15:0] id_d    [QUEUE_DEPTH];
  logic [7:0]  hnd_q   [QUEUE_DEPTH];
  logic [7:0]  hnd_d   [QUEUE_DEPTH];
  logic [15:0] arg_q   [QUEUE_DEPTH];
  logic [15:0] arg_d   [QUEUE_DEPTH];
  logic        canc_q  [QUEUE_DEPTH];
  logic        canc_d  [QUEUE_DEPTH];

  logic [LW-1:0]             len_q, len_d;
  logic [15:0]               next_id_q, next_id_d;
  logic [15:0]               new_id_q;
  logic [31:0]               ticks_q;
  logic [LW-1:0]             pos_q;
  logic [dqts_pkg::NCntW-1:0] count_q;
  dqts_pkg::req_t            req_q;
  logic                      pend_valid_q;
  logic [15:0]               pend_id_q;
  logic [7:0]                pend_hnd_q;
  logic [15:0]               pend_arg_q;
  dqts_pkg::rsp_t            out_q, out_d;
  logic                      out_valid_q;

  logic [15:0] cand;
  logic        in_use;
  logic        cancel_hit;
  logic [31:0] scan_delta;
  logic        out_free;

  assign cand       = (next_id_q == 16'd0) ? 16'd1 : next_id_q;
  assign scan_delta = delta_q[pos_q[IW-1:0]];
  assign out_free   = !out_valid_q || !out_stall_i;

  // id compares over the live entries
  always_comb begin
    in_use     = 1'b0;
    cancel_hit = 1'b0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (LW'(i) < len_q) begin
        if (id_q[i] == cand) in_use = 1'b1;
        if (id_q[i] == req_q.cancel_id) cancel_hit = 1'b1;
      end
    end
  end

  // status
  always_comb begin
    stat_o.full        = (len_q == LW'(QUEUE_DEPTH));
    stat_o.empty       = (len_q == '0);
    stat_o.out_free    = out_free;
    stat_o.id_in_use   = in_use;
    stat_o.scan_more   = (pos_q < len_q);
    stat_o.scan_hit    = (ticks_q < scan_delta);
    stat_o.head_zero   = (delta_q[0] == 32'd0);
    stat_o.head_cancel = canc_q[0];
    stat_o.count_max   = (count_q == dqts_pkg::NCntW'(dqts_pkg::MaxResults));
    stat_o.pend_valid  = pend_valid_q;
  end

  // entry updates
  always_comb begin
    delta_d = delta_q;
    id_d    = id_q;
    hnd_d   = hnd_q;
    arg_d   = arg_q;
    canc_d  = canc_q;
    len_d   = len_q;
    if (ctrl_i.place) begin
      // open a slot at pos, the old entry there gives up the new delta
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (LW'(i) > pos_q && LW'(i) <= len_q) begin
          delta_d[i] = (LW'(i - 1) == pos_q) ? delta_q[i-1] - ticks_q : delta_q[i-1];
          id_d[i]    = id_q[i-1];
          hnd_d[i]   = hnd_q[i-1];
          arg_d[i]   = arg_q[i-1];
          canc_d[i]  = canc_q[i-1];
        end
      end
      delta_d[pos_q[IW-1:0]] = ticks_q;
      id_d[pos_q[IW-1:0]]    = new_id_q;
      hnd_d[pos_q[IW-1:0]]   = req_q.handler_tag;
      arg_d[pos_q[IW-1:0]]   = req_q.handler_argument;
      canc_d[pos_q[IW-1:0]]  = 1'b0;
      len_d = len_q + LW'(1);
    end else if (ctrl_i.drop_head) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        delta_d[i] = delta_q[i+1];
        id_d[i]    = id_q[i+1];
        hnd_d[i]   = hnd_q[i+1];
        arg_d[i]   = arg_q[i+1];
        canc_d[i]  = canc_q[i+1];
      end
      len_d = len_q - LW'(1);
    end else if (ctrl_i.dec_head) begin
      if (delta_q[0] != 32'd0) delta_d[0] = delta_q[0] - 32'd1;
    end else if (ctrl_i.cancel_mark) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        if (LW'(i) < len_q && id_q[i] == req_q.cancel_id) canc_d[i] = 1'b1;
      end
    end
  end

  // result selection
  always_comb begin
    out_d = '0;
    out_d.last_result = ctrl_i.emit_last;
    case (ctrl_i.emit)
      dqts_pkg::EMIT_FULL: begin
        out_d.result_kind = dqts_pkg::KIND_INSERT_ACK;
      end
      dqts_pkg::EMIT_INSERT: begin
        out_d.result_kind = dqts_pkg::KIND_INSERT_ACK;
        out_d.timer_id    = new_id_q;
      end
      dqts_pkg::EMIT_CANCEL: begin
        out_d.result_kind  = dqts_pkg::KIND_CANCEL_ACK;
        out_d.timer_id     = req_q.cancel_id;
        out_d.cancel_found = cancel_hit;
      end
      dqts_pkg::EMIT_PEND: begin
        out_d.result_kind      = dqts_pkg::KIND_EXPIRY;
        out_d.timer_id         = pend_id_q;
        out_d.expired_handler  = pend_hnd_q;
        out_d.expired_argument = pend_arg_q;
      end
      default: out_d = out_q;
    endcase
  end

  assign next_id_d = ctrl_i.pick_id ? cand + 16'd1 : next_id_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    id_q    <= id_d;
    hnd_q   <= hnd_d;
    arg_q   <= arg_d;
    canc_q  <= canc_d;
    if (ctrl_i.load_req) begin
      req_q   <= in_req_i;
      ticks_q <= (in_req_i.delay_ticks == 32'd0) ? 32'd1 : in_req_i.delay_ticks;
    end else if (ctrl_i.scan_step) begin
      ticks_q <= ticks_q - scan_delta;
    end
    if (ctrl_i.pick_id) new_id_q <= cand;
    if (ctrl_i.take_pend) begin
      pend_id_q  <= id_q[0];
      pend_hnd_q <= hnd_q[0];
      pend_arg_q <= arg_q[0];
    end
    if (ctrl_i.emit != dqts_pkg::EMIT_NONE) out_q <= out_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q        <= '0;
      next_id_q    <= '0;
      pos_q        <= '0;
      count_q      <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      len_q     <= len_d;
      next_id_q <= next_id_d;
      if (ctrl_i.load_req) begin
        pos_q <= '0;
      end else if (ctrl_i.scan_step) begin
        pos_q <= pos_q + LW'(1);
      end
      if (ctrl_i.clr_count) begin
        count_q <= '0;
      end else if (ctrl_i.take_pend) begin
        count_q <= count_q + dqts_pkg::NCntW'(1);
      end
      if (ctrl_i.take_pend) begin
        pend_valid_q <= 1'b1;
      end else if (ctrl_i.emit == dqts_pkg::EMIT_PEND) begin
        pend_valid_q <= 1'b0;
      end
      if (ctrl_i.emit != dqts_pkg::EMIT_NONE) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

// ===== hw/rtl/delta_queue_timeout_scheduler_core.sv =====
// top level of the delta queue timeout scheduler
//
//  channel  handshake               payload
//  in       in_valid_i/in_stall_o   in_req_i  (dqts_pkg::req_t)
//  out      out_valid_o/out_stall_i out_rsp_o (dqts_pkg::rsp_t)
//
// one request at a time; the entries sit in flip-flops, head at slot 0
// insert: accept, try ids until a free one is found, walk the entries through the single
//   delta read port to find the slot, then place; cancel: accept, then mark and answer
// tick: accept, end on an empty queue, else decrement the head, then drop or expire entries
// reset empties the queue at once; a stalled output holds a request only where it emits
module delta_queue_timeout_scheduler_core #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  dqts_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output dqts_pkg::rsp_t out_rsp_o
);

  dqts_pkg::ctrl_t ctrl;
  dqts_pkg::stat_t stat;

  dqts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_command_i (in_req_i.command),
    .in_stall_o   (in_stall_o),
    .stat_i       (stat),
    .ctrl_o       (ctrl)
  );

  dqts_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_req_i    (in_req_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_rsp_o   (out_rsp_o),
    .ctrl_i      (ctrl),
    .stat_o      (stat)
  );

  // a taken request other than a no-op blocks the input until it is done
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_req_i.command != dqts_pkg::CMD_NOP))
    |=> in_stall_o)
    else $error("input not stalled after request");

  // no held expiry remains once the block is idle
  a_no_pend_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.pend_valid)
    else $error("expiry left pending at idle");

  // a new result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit != dqts_pkg::EMIT_NONE) |-> stat.out_free)
    else $error("result loaded over a waiting result");

endmodule
